>>> design/rmlm_pkg.sv
// ----------------------------------------------------------------------------
// rmlm_pkg - lock manager shared types and constants
// Request/result structs, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package rmlm_pkg;

  localparam int MUTEX_SLOTS = 16;
  localparam int THREADS     = 16;
  localparam int COUNT_BITS  = 32;
  localparam int SLOT_W      = 4;
  localparam int THR_W       = 4;
  localparam int QCNT_W      = 5;
  localparam int QADDR_W     = SLOT_W + THR_W;
  localparam int QDEPTH      = MUTEX_SLOTS * THREADS;
  localparam logic [COUNT_BITS-1:0] DEPTH_MAX = '1;
  localparam int FIFO_DEPTH  = 2;

  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_DESTROY = 3'd1,
    REQ_LOCK    = 3'd2,
    REQ_TRYLOCK = 3'd3,
    REQ_UNLOCK  = 3'd4,
    REQ_CANCEL  = 3'd5
  } req_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_NOSUCH   = 4'd1,
    ST_INVAL    = 4'd2,
    ST_BUSY     = 4'd3,
    ST_PERM     = 4'd4,
    ST_DEADLK   = 4'd5,
    ST_OVERFLOW = 4'd6,
    ST_TIMEDOUT = 4'd7,
    ST_QUEUED   = 4'd8,
    ST_NOSLOT   = 4'd9
  } status_t;

  localparam logic [1:0] PROTO_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] mutex_slot;
    logic [3:0] thread_id;
    logic [1:0] protocol_code;
    logic [1:0] recursive_code;
    logic       other_attrs_ok;
    logic       has_cond_users;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [3:0] new_slot;
    logic       wake_valid;
    logic [3:0] wake_thread;
  } out_item_t;

  // Classified command handed from front to back.
  typedef enum logic [2:0] {
    CMD_REPLY,    // answer precomputed, no state access
    CMD_CREATE,
    CMD_DESTROY,
    CMD_ACQUIRE,
    CMD_UNLOCK,
    CMD_CANCEL
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [3:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [THR_W-1:0]  thread;
    logic              wait_ok;
    logic              rec;
    logic              conds;
  } task_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_RD,     // queue entry read issued
    SQ_SCAN,   // compare one queue entry
    SQ_SHIFT,  // move one entry down
    SQ_SHWR,   // write shifted entry
    SQ_DONE
  } seq_t;

endpackage
`default_nettype wire

>>> design/rmlm_ram.sv
// ----------------------------------------------------------------------------
// rmlm_ram - generic single-port-write, one-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rmlm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

>>> design/rmlm_front.sv
// ----------------------------------------------------------------------------
// rmlm_front - request classifier and task queue
// Checks field ranges and attributes, pushes a task into a small FIFO.
// ----------------------------------------------------------------------------
`default_nettype none
module rmlm_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rmlm_pkg::in_item_t in_data,
  output logic                   tq_valid,
  output rmlm_pkg::task_t        tq_task,
  input  wire logic              tq_pop
);
  rmlm_pkg::task_t  fifo_r [rmlm_pkg::FIFO_DEPTH];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  rmlm_pkg::task_t  tk;
  logic             push;

  always_comb begin
    tk = '0;
    tk.slot    = in_data.mutex_slot;
    tk.thread  = in_data.thread_id;
    tk.wait_ok = (in_data.req_type == rmlm_pkg::REQ_LOCK);
    tk.rec     = in_data.recursive_code[0];
    tk.conds   = in_data.has_cond_users;
    tk.status  = rmlm_pkg::ST_OK;
    case (in_data.req_type)
      rmlm_pkg::REQ_CREATE: begin
        if (in_data.protocol_code == rmlm_pkg::PROTO_UNKNOWN ||
            in_data.recursive_code[1] || !in_data.other_attrs_ok) begin
          tk.cmd    = rmlm_pkg::CMD_REPLY;
          tk.status = rmlm_pkg::ST_INVAL;
        end else begin
          tk.cmd = rmlm_pkg::CMD_CREATE;
        end
      end
      rmlm_pkg::REQ_DESTROY: tk.cmd = rmlm_pkg::CMD_DESTROY;
      rmlm_pkg::REQ_LOCK,
      rmlm_pkg::REQ_TRYLOCK: tk.cmd = rmlm_pkg::CMD_ACQUIRE;
      rmlm_pkg::REQ_UNLOCK:  tk.cmd = rmlm_pkg::CMD_UNLOCK;
      rmlm_pkg::REQ_CANCEL:  tk.cmd = rmlm_pkg::CMD_CANCEL;
      default: begin
        tk.cmd    = rmlm_pkg::CMD_REPLY;
        tk.status = rmlm_pkg::ST_INVAL;
      end
    endcase
  end

  assign in_stall = (cnt_r == 2'(rmlm_pkg::FIFO_DEPTH));
  assign push     = in_valid && !in_stall;
  assign tq_valid = (cnt_r != 2'd0);
  assign tq_task  = fifo_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = (tq_pop && tq_valid) ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(tq_pop && tq_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= tk;
    end
  end
endmodule
`default_nettype wire

>>> design/rmlm_back.sv
// ----------------------------------------------------------------------------
// rmlm_back - mutex table and wait-queue sequencer
// Executes one task at a time against the table and queue RAM.
// ----------------------------------------------------------------------------
`default_nettype none
module rmlm_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                tq_valid,
  input  wire rmlm_pkg::task_t     tq_task,
  output logic                     tq_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rmlm_pkg::out_item_t      out_data
);
  localparam int SW = rmlm_pkg::SLOT_W;
  localparam int TW = rmlm_pkg::THR_W;
  localparam int CW = rmlm_pkg::COUNT_BITS;
  localparam int QW = rmlm_pkg::QCNT_W;

  logic [rmlm_pkg::MUTEX_SLOTS-1:0] use_r, use_nxt, rec_r, rec_nxt, own_r, own_nxt;
  logic [TW-1:0] oth_r [rmlm_pkg::MUTEX_SLOTS];
  logic [TW-1:0] oth_nxt [rmlm_pkg::MUTEX_SLOTS];
  logic [CW-1:0] dep_r [rmlm_pkg::MUTEX_SLOTS];
  logic [CW-1:0] dep_nxt [rmlm_pkg::MUTEX_SLOTS];
  logic [TW-1:0] hd_r [rmlm_pkg::MUTEX_SLOTS];
  logic [TW-1:0] hd_nxt [rmlm_pkg::MUTEX_SLOTS];
  logic [QW-1:0] wc_r [rmlm_pkg::MUTEX_SLOTS];
  logic [QW-1:0] wc_nxt [rmlm_pkg::MUTEX_SLOTS];

  rmlm_pkg::seq_t      st_r, st_nxt;
  rmlm_pkg::task_t     tk_r, tk_nxt;
  logic [QW-1:0]       idx_r, idx_nxt;     // queue position under work
  logic                found_r, found_nxt;
  rmlm_pkg::out_item_t res_r, res_nxt;
  logic                ov_r, ov_nxt;

  logic          wr_en;
  logic [rmlm_pkg::QADDR_W-1:0] wr_addr, rd_addr;
  logic [TW-1:0] wr_data, rd_data;

  rmlm_ram #(.WIDTH(TW), .DEPTH(rmlm_pkg::QDEPTH)) u_wq (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  logic [SW-1:0] s;
  logic [TW-1:0] t;
  logic          is_own;
  logic          free_any;
  logic [SW-1:0] free_idx;

  assign s = tk_r.slot;
  assign t = tk_r.thread;
  assign is_own = own_r[s] && (oth_r[s] == t);

  function automatic logic [TW-1:0] qpos(logic [TW-1:0] hd, logic [QW-1:0] i);
    logic [QW-1:0] sum;
    begin
      sum = QW'(hd) + i;
      return sum[TW-1:0];
    end
  endfunction

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = rmlm_pkg::MUTEX_SLOTS - 1; i >= 0; i--) begin
      if (!use_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign out_valid = ov_r;
  assign out_data  = res_r;
  assign tq_pop    = (st_r == rmlm_pkg::SQ_IDLE) && tq_valid;

  // Next-state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rmlm_pkg::SQ_IDLE: if (tq_valid) st_nxt = rmlm_pkg::SQ_RD;
      rmlm_pkg::SQ_RD: begin
        if (!use_r[s] && tk_r.cmd != rmlm_pkg::CMD_CREATE &&
            tk_r.cmd != rmlm_pkg::CMD_REPLY) begin
          st_nxt = rmlm_pkg::SQ_DONE;
        end else if ((tk_r.cmd == rmlm_pkg::CMD_CANCEL ||
                      (tk_r.cmd == rmlm_pkg::CMD_ACQUIRE && tk_r.wait_ok &&
                       own_r[s] && !is_own)) && idx_r < wc_r[s]) begin
          st_nxt = rmlm_pkg::SQ_SCAN;
        end else begin
          st_nxt = rmlm_pkg::SQ_DONE;
        end
      end
      rmlm_pkg::SQ_SCAN: begin
        if (rd_data == t) begin
          st_nxt = (tk_r.cmd == rmlm_pkg::CMD_CANCEL) ? rmlm_pkg::SQ_SHIFT
                                                       : rmlm_pkg::SQ_DONE;
        end else if (idx_r + QW'(1) < wc_r[s]) begin
          st_nxt = rmlm_pkg::SQ_SCAN;
        end else begin
          st_nxt = rmlm_pkg::SQ_DONE;
        end
      end
      rmlm_pkg::SQ_SHIFT:
        st_nxt = (idx_r + QW'(1) < wc_r[s]) ? rmlm_pkg::SQ_SHWR : rmlm_pkg::SQ_DONE;
      rmlm_pkg::SQ_SHWR: st_nxt = rmlm_pkg::SQ_SHIFT;
      rmlm_pkg::SQ_DONE: if (!ov_r || !out_stall) st_nxt = rmlm_pkg::SQ_IDLE;
      default: st_nxt = rmlm_pkg::SQ_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    tk_nxt    = tk_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && out_stall;
    use_nxt = use_r; rec_nxt = rec_r; own_nxt = own_r;
    oth_nxt = oth_r; dep_nxt = dep_r; hd_nxt = hd_r; wc_nxt = wc_r;
    wr_en   = 1'b0;
    wr_addr = {s, qpos(hd_r[s], idx_r)};
    wr_data = t;
    rd_addr = {s, qpos(hd_r[s], idx_r)};
    case (st_r)
      rmlm_pkg::SQ_IDLE: begin
        tk_nxt    = tq_task;
        idx_nxt   = '0;
        found_nxt = 1'b0;
        rd_addr   = {tq_task.slot, qpos(hd_r[tq_task.slot], '0)};
      end
      rmlm_pkg::SQ_RD: begin
        rd_addr = {s, qpos(hd_r[s], idx_r)};
      end
      rmlm_pkg::SQ_SCAN: begin
        if (rd_data == t) begin
          found_nxt = 1'b1;
          rd_addr   = {s, qpos(hd_r[s], idx_r + QW'(1))};
        end else begin
          idx_nxt = idx_r + QW'(1);
          rd_addr = {s, qpos(hd_r[s], idx_r + QW'(1))};
        end
      end
      rmlm_pkg::SQ_SHIFT: begin
        rd_addr = {s, qpos(hd_r[s], idx_r + QW'(1))};
      end
      rmlm_pkg::SQ_SHWR: begin
        // rd_data holds entry idx+1; move it down
        wr_en   = 1'b1;
        wr_addr = {s, qpos(hd_r[s], idx_r)};
        wr_data = rd_data;
        idx_nxt = idx_r + QW'(1);
        rd_addr = {s, qpos(hd_r[s], idx_r + QW'(2))};
      end
      rmlm_pkg::SQ_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt  = 1'b1;
          res_nxt = '0;
          res_nxt.status = rmlm_pkg::ST_OK;
          case (tk_r.cmd)
            rmlm_pkg::CMD_REPLY: res_nxt.status = tk_r.status;
            rmlm_pkg::CMD_CREATE: begin
              if (!free_any) begin
                res_nxt.status = rmlm_pkg::ST_NOSLOT;
              end else begin
                use_nxt[free_idx] = 1'b1;
                rec_nxt[free_idx] = tk_r.rec;
                own_nxt[free_idx] = 1'b0;
                oth_nxt[free_idx] = '0;
                dep_nxt[free_idx] = '0;
                hd_nxt[free_idx]  = '0;
                wc_nxt[free_idx]  = '0;
                res_nxt.new_slot  = free_idx;
              end
            end
            default: begin
              if (!use_r[s]) begin
                res_nxt.status = rmlm_pkg::ST_NOSUCH;
              end else begin
                case (tk_r.cmd)
                  rmlm_pkg::CMD_DESTROY: begin
                    if (own_r[s] || wc_r[s] != '0) begin
                      res_nxt.status = rmlm_pkg::ST_BUSY;
                    end else if (tk_r.conds) begin
                      res_nxt.status = rmlm_pkg::ST_PERM;
                    end else begin
                      use_nxt[s] = 1'b0;
                      rec_nxt[s] = 1'b0;
                      dep_nxt[s] = '0;
                      hd_nxt[s]  = '0;
                    end
                  end
                  rmlm_pkg::CMD_ACQUIRE: begin
                    if (is_own) begin
                      if (!rec_r[s]) res_nxt.status = rmlm_pkg::ST_DEADLK;
                      else if (dep_r[s] == rmlm_pkg::DEPTH_MAX)
                        res_nxt.status = rmlm_pkg::ST_OVERFLOW;
                      else dep_nxt[s] = dep_r[s] + CW'(1);
                    end else if (!own_r[s]) begin
                      own_nxt[s] = 1'b1;
                      oth_nxt[s] = t;
                      dep_nxt[s] = '0;
                    end else if (!tk_r.wait_ok) begin
                      res_nxt.status = rmlm_pkg::ST_BUSY;
                    end else begin
                      res_nxt.status = rmlm_pkg::ST_QUEUED;
                      if (!found_r && wc_r[s] < QW'(rmlm_pkg::THREADS)) begin
                        wr_en   = 1'b1;
                        wr_addr = {s, qpos(hd_r[s], wc_r[s])};
                        wr_data = t;
                        wc_nxt[s] = wc_r[s] + QW'(1);
                      end
                    end
                  end
                  rmlm_pkg::CMD_UNLOCK: begin
                    if (!is_own) begin
                      res_nxt.status = rmlm_pkg::ST_PERM;
                    end else if (dep_r[s] != '0) begin
                      dep_nxt[s] = dep_r[s] - CW'(1);
                    end else if (wc_r[s] != '0) begin
                      // rd_data holds the head entry read at task start
                      res_nxt.wake_valid  = 1'b1;
                      res_nxt.wake_thread = rd_data;
                      oth_nxt[s] = rd_data;
                      hd_nxt[s]  = hd_r[s] + TW'(1);
                      wc_nxt[s]  = wc_r[s] - QW'(1);
                    end else begin
                      own_nxt[s] = 1'b0;
                    end
                  end
                  rmlm_pkg::CMD_CANCEL: begin
                    if (found_r) begin
                      res_nxt.status = rmlm_pkg::ST_TIMEDOUT;
                      wc_nxt[s] = wc_r[s] - QW'(1);
                    end else if (is_own) begin
                      res_nxt.status = rmlm_pkg::ST_OK;
                    end else begin
                      res_nxt.status = rmlm_pkg::ST_INVAL;
                    end
                  end
                  default: res_nxt.status = rmlm_pkg::ST_INVAL;
                endcase
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= rmlm_pkg::SQ_IDLE;
      ov_r  <= 1'b0;
      use_r <= '0;
      rec_r <= '0;
      own_r <= '0;
      for (int i = 0; i < rmlm_pkg::MUTEX_SLOTS; i++) begin
        oth_r[i] <= '0;
        dep_r[i] <= '0;
        hd_r[i]  <= '0;
        wc_r[i]  <= '0;
      end
    end else begin
      st_r  <= st_nxt;
      ov_r  <= ov_nxt;
      use_r <= use_nxt;
      rec_r <= rec_nxt;
      own_r <= own_nxt;
      oth_r <= oth_nxt;
      dep_r <= dep_nxt;
      hd_r  <= hd_nxt;
      wc_r  <= wc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tk_r    <= tk_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
  end
endmodule
`default_nettype wire

>>> design/recursive_mutex_lock_manager.sv
// ----------------------------------------------------------------------------
// recursive_mutex_lock_manager - hardware recursive mutex table
// Sixteen mutexes with owner, recursion count and FIFO wait queue each.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | rmlm_pkg::in_item_t
//   out_    | output    | out_valid/out_stall| rmlm_pkg::out_item_t
//
// A request passes through the back sequencer in order: pop, queue read,
// commit; lock and cancel also scan the wait queue entry by entry, and
// cancel shifts each entry behind the match down, all bound by the single
// queue RAM port. The front queue holds two requests, so input is taken
// while the back is busy until it fills. Reset empties the table and both
// queues at once; the wait RAM needs no clearing. A stalled result holds in
// the output register and stops the back at its next commit until taken.
// ----------------------------------------------------------------------------
`default_nettype none
module recursive_mutex_lock_manager (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rmlm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rmlm_pkg::out_item_t      out_data
);
  logic            tq_valid, tq_pop;
  rmlm_pkg::task_t tq_task;

  // Classify and buffer requests.
  rmlm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .tq_valid(tq_valid), .tq_task(tq_task), .tq_pop(tq_pop)
  );

  // Execute against the mutex table.
  rmlm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .tq_valid(tq_valid), .tq_task(tq_task), .tq_pop(tq_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
`default_nettype wire
